/* hw/rtl/psd_pkg.sv */
// Shared constants and types for the point-to-segment distance block.
package psd_pkg;

  localparam int DIST_BITS   = 25;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_BITS   = 3;
  localparam int STEP_BITS   = 5;

  typedef enum logic [1:0] {
    CASE_DEGEN  = 2'd0,
    CASE_NEAR_A = 2'd1,
    CASE_NEAR_B = 2'd2,
    CASE_PERP   = 2'd3
  } case_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } root_state_t;

endpackage

/* hw/rtl/psd_front.sv */
// Front pipeline: coordinate differences, products, case selection and radicand.
module psd_front #(
  parameter int COORD_BITS = 16,
  parameter int SQ_BITS    = 33
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  output logic [2*SQ_BITS-1:0]         out_num,
  output logic [SQ_BITS-1:0]           out_den,
  output psd_pkg::case_t               out_code
);

  localparam int DB = COORD_BITS + 1;
  localparam int PB = 2 * DB;
  localparam int SB = PB + 1;

  logic                 v1, v2, v3;
  logic signed [DB-1:0] apx, apy, abx, aby, bpx, bpy;
  logic signed [PB-1:0] m_abx2, m_aby2, m_dot1, m_dot2, m_cr1, m_cr2;
  logic signed [PB-1:0] m_pax2, m_pay2, m_pbx2, m_pby2;
  logic [SQ_BITS-1:0]   base;
  logic [SQ_BITS-1:0]   den3;
  logic                 perp3;
  psd_pkg::case_t       code3;

  logic signed [SB-1:0] len2_s, dot_s, cross_s, pa_s, pb_s, cross_mag;
  logic [SQ_BITS-1:0]   sel_base, sel_den;
  logic                 sel_perp;
  psd_pkg::case_t       sel_code;
  logic [SQ_BITS-1:0]   mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // Stage 1: differences, one bit wider than the coordinates.
  always_ff @(posedge clk) begin
    apx <= DB'(point_x) - DB'(start_x);
    apy <= DB'(point_y) - DB'(start_y);
    abx <= DB'(end_x) - DB'(start_x);
    aby <= DB'(end_y) - DB'(start_y);
    bpx <= DB'(point_x) - DB'(end_x);
    bpy <= DB'(point_y) - DB'(end_y);
  end

  // Stage 2: all products in parallel.
  always_ff @(posedge clk) begin
    m_abx2 <= abx * abx;
    m_aby2 <= aby * aby;
    m_dot1 <= apx * abx;
    m_dot2 <= apy * aby;
    m_cr1  <= apx * aby;
    m_cr2  <= apy * abx;
    m_pax2 <= apx * apx;
    m_pay2 <= apy * apy;
    m_pbx2 <= bpx * bpx;
    m_pby2 <= bpy * bpy;
  end

  // Stage 3: sums and classification.
  always_comb begin
    len2_s    = SB'(m_abx2) + SB'(m_aby2);
    dot_s     = SB'(m_dot1) + SB'(m_dot2);
    cross_s   = SB'(m_cr1) - SB'(m_cr2);
    pa_s      = SB'(m_pax2) + SB'(m_pay2);
    pb_s      = SB'(m_pbx2) + SB'(m_pby2);
    cross_mag = cross_s[SB-1] ? -cross_s : cross_s;
    sel_den   = SQ_BITS'(1);
    sel_perp  = 1'b0;
    if (len2_s == '0) begin
      sel_base = SQ_BITS'(pa_s);
      sel_code = psd_pkg::CASE_DEGEN;
    end else if (dot_s < 0) begin
      sel_base = SQ_BITS'(pa_s);
      sel_code = psd_pkg::CASE_NEAR_A;
    end else if (dot_s > len2_s) begin
      sel_base = SQ_BITS'(pb_s);
      sel_code = psd_pkg::CASE_NEAR_B;
    end else begin
      sel_base = SQ_BITS'(cross_mag);
      sel_den  = SQ_BITS'(len2_s);
      sel_perp = 1'b1;
      sel_code = psd_pkg::CASE_PERP;
    end
  end

  always_ff @(posedge clk) begin
    base  <= sel_base;
    den3  <= sel_den;
    perp3 <= sel_perp;
    code3 <= sel_code;
  end

  // Stage 4: the interior case squares the cross product, others pass through.
  assign mul_b = perp3 ? base : SQ_BITS'(1);

  always_ff @(posedge clk) begin
    out_num  <= base * mul_b;
    out_den  <= den3;
    out_code <= code3;
  end

endmodule

/* hw/rtl/psd_queue.sv */
// Short request queue between the front pipeline and the root unit.
module psd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0]                 slots [psd_pkg::QUEUE_DEPTH];
  logic [psd_pkg::QPTR_BITS-1:0]    head, tail;
  logic [psd_pkg::QPTR_BITS:0]      fill;

  assign empty    = (fill == '0);
  assign pop_data = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      fill <= fill + (psd_pkg::QPTR_BITS+1)'(push) - (psd_pkg::QPTR_BITS+1)'(pop);
    end
  end

endmodule

/* hw/rtl/psd_root.sv */
// Bit-serial scaled root: largest d with d*d*den <= num * 2^(2*FRAC_BITS).
module psd_root #(
  parameter int FRAC_BITS = 8,
  parameter int SQ_BITS   = 33
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [2*SQ_BITS-1:0]              in_num,
  input  logic [SQ_BITS-1:0]                in_den,
  input  psd_pkg::case_t                    in_code,
  output logic                              in_pop,
  output logic                              done,
  output logic [psd_pkg::DIST_BITS-1:0]     distance,
  output logic [1:0]                        nearest_case
);

  localparam int DB = psd_pkg::DIST_BITS;
  localparam int RB = 2 * SQ_BITS + 2 * FRAC_BITS;
  localparam int QB = 2 * DB + SQ_BITS;
  localparam int W  = ((RB > QB) ? RB : QB) + 2;

  psd_pkg::root_state_t            state, state_next;
  logic [W-1:0]                    rem, q, e, trial, q_upd;
  logic [DB-1:0]                   d, d_new;
  logic [psd_pkg::STEP_BITS-1:0]   step;
  psd_pkg::case_t                  code;
  logic                            fits, last;

  // rem holds num - d*d*den; q is d*den shifted to the current bit; e is den at bit squared.
  always_comb begin
    trial = q + e;
    fits  = (trial <= rem);
    d_new = d | (fits ? (DB'(1) << step) : '0);
    q_upd = fits ? (q + (e << 1)) : q;
    last  = (step == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psd_pkg::ST_IDLE: if (in_valid) state_next = psd_pkg::ST_RUN;
      psd_pkg::ST_RUN:  if (last) state_next = psd_pkg::ST_IDLE;
      default:          state_next = psd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      psd_pkg::ST_IDLE: in_pop = in_valid;
      default:          in_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psd_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == psd_pkg::ST_RUN) && last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      rem  <= W'(in_num) << (2 * FRAC_BITS);
      q    <= '0;
      e    <= W'(in_den) << (2 * (DB - 1));
      d    <= '0;
      step <= psd_pkg::STEP_BITS'(DB - 1);
      code <= in_code;
    end else if (state == psd_pkg::ST_RUN) begin
      if (fits) begin
        rem <= rem - trial;
      end
      d    <= d_new;
      q    <= q_upd >> 1;
      e    <= e >> 2;
      step <= step - 1'b1;
      if (last) begin
        distance     <= d_new;
        nearest_case <= code;
      end
    end
  end

endmodule

/* hw/rtl/point_segment_distance.sv */
// Top level of the point-to-segment distance block.
//
// A request carries a query point and the two endpoints of a segment as signed
// coordinates. It is taken at a rising clock edge where start is high and busy
// is low. The block answers with the distance from the point to the segment,
// scaled by 2^FRAC_BITS and floored, and a code telling which part of the
// segment is nearest. The answer is shown for exactly one cycle with done high;
// the receiver cannot hold it off, so nothing downstream ever stalls.
// A four-stage front pipeline takes a request every cycle while busy is low
// and feeds an eight-entry queue. A bit-serial root unit drains the queue,
// one result bit per cycle; it pops the next request only once it has finished
// the last one, so it sets the sustained rate, while bursts of up to eight
// requests are taken back to back. From acceptance to done a request passes
// through the front pipeline, the queue and the root unit, and may also wait
// behind earlier requests. busy rises when eight requests are in flight. A
// synchronous reset empties the pipeline, the queue and the root unit; no
// result is shown during or just after reset.
module point_segment_distance #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      point_x,
  input  logic signed [COORD_BITS-1:0]      point_y,
  input  logic signed [COORD_BITS-1:0]      start_x,
  input  logic signed [COORD_BITS-1:0]      start_y,
  input  logic signed [COORD_BITS-1:0]      end_x,
  input  logic signed [COORD_BITS-1:0]      end_y,
  output logic                              done,
  output logic [psd_pkg::DIST_BITS-1:0]     distance,
  output logic [1:0]                        nearest_case
);

  // Squared lengths and the cross product magnitude stay below 2^(2*COORD_BITS+1).
  localparam int SQ_BITS = 2 * COORD_BITS + 1;
  localparam int QW      = 2 * SQ_BITS + SQ_BITS + 2;

  logic                          accept;
  logic [psd_pkg::QPTR_BITS:0]   in_flight;
  logic                          f_valid;
  logic [2*SQ_BITS-1:0]          f_num;
  logic [SQ_BITS-1:0]            f_den;
  psd_pkg::case_t                f_code;
  logic [QW-1:0]                 q_out;
  logic                          q_empty, q_pop;

  // Every request in flight is counted until its result leaves, so the queue
  // always has room for whatever the front pipeline still holds.
  assign busy   = (in_flight >= (psd_pkg::QPTR_BITS+1)'(psd_pkg::QUEUE_DEPTH));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + (psd_pkg::QPTR_BITS+1)'(accept)
                             - (psd_pkg::QPTR_BITS+1)'(done);
    end
  end

  psd_front #(
    .COORD_BITS (COORD_BITS),
    .SQ_BITS    (SQ_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .point_x   (point_x),
    .point_y   (point_y),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (f_valid),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_code  (f_code)
  );

  psd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data ({f_num, f_den, f_code}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  psd_root #(
    .FRAC_BITS (FRAC_BITS),
    .SQ_BITS   (SQ_BITS)
  ) u_root (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (!q_empty),
    .in_num       (q_out[QW-1 -: 2*SQ_BITS]),
    .in_den       (q_out[SQ_BITS+1:2]),
    .in_code      (psd_pkg::case_t'(q_out[1:0])),
    .in_pop       (q_pop),
    .done         (done),
    .distance     (distance),
    .nearest_case (nearest_case)
  );

  // The root unit passes through idle between results, so done is never high on consecutive cycles.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");

  // The in-flight count never passes the queue depth.
  assert property (@(posedge clk) disable iff (rst)
    in_flight <= (psd_pkg::QPTR_BITS+1)'(psd_pkg::QUEUE_DEPTH))
    else $error("in-flight count overflow");

  // No result appears right after a reset cycle.
  assert property (@(posedge clk) rst |=> !done)
    else $error("result shown after reset");

  // A result is only shown while some request is counted in flight.
  assert property (@(posedge clk) disable iff (rst) done |-> (in_flight != '0))
    else $error("result without a pending request");

endmodule
